/* rtl/bfs_pkg.sv */
// ----------------------------------------------------------------------------
// bfs_pkg: shared types and constants of the burst fire sequencer
// Holds the fire phase encoding, register indexes, reset values of the
// configuration registers and the timer load helper.
// ----------------------------------------------------------------------------
package bfs_pkg;

   // Timer geometry and the fixed reload gap.
   localparam int unsigned TIMER_WIDTH = 16;
   localparam int unsigned RELOAD_GAP  = 60;

   typedef logic [TIMER_WIDTH-1:0] timer_type;
   localparam timer_type TIMER_MAX = '1;

   // Ticks since the last shot saturate at the smaller of the timer range
   // and the 16-bit field.
   localparam logic [15:0] SINCE_MAX = (TIMER_WIDTH < 16) ? 16'(TIMER_MAX) : 16'hFFFF;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_DELAY   = 3'd1,
      PH_RELEASE = 3'd2,
      PH_GAP     = 3'd3,
      PH_HOLDOFF = 3'd4,
      PH_REARM   = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      CSR_MAX_AMMO      = 3'd0,
      CSR_RELOAD_STEP   = 3'd1,
      CSR_SHOTS         = 3'd2,
      CSR_SHOT_GAP      = 3'd3,
      CSR_TRIG_DELAY    = 3'd4,
      CSR_HOLDOFF       = 3'd5,
      CSR_RELOAD_AFTER  = 3'd6,
      CSR_RELEASE_MODE  = 3'd7
   } csr_index_type;

   localparam int unsigned CSR_DATA_WIDTH = 16;

   // Reset values of the configuration registers.
   localparam logic [7:0]  RST_MAX_AMMO     = 8'd50;
   localparam logic [7:0]  RST_RELOAD_STEP  = 8'd50;
   localparam logic [7:0]  RST_SHOTS        = 8'd3;
   localparam logic [15:0] RST_SHOT_GAP     = 16'd70;
   localparam logic [15:0] RST_TRIG_DELAY   = 16'd0;
   localparam logic [15:0] RST_HOLDOFF      = 16'd200;
   localparam logic [15:0] RST_RELOAD_AFTER = 16'd600;
   localparam logic [1:0]  RST_RELEASE_MODE = 2'd0;

   // Release mode bits.
   localparam int unsigned RM_FIRE_ON_RELEASE  = 0;
   localparam int unsigned RM_REARM_ON_RELEASE = 1;

   typedef struct packed {
      logic [7:0]  max_ammo;
      logic [7:0]  reload_step;
      logic [7:0]  shots_per_burst;
      logic [15:0] shot_gap;
      logic [15:0] trigger_delay;
      logic [15:0] burst_holdoff;
      logic [15:0] reload_after_shot;
      logic [1:0]  release_mode;
   } cfg_type;

   typedef struct packed {
      logic        shot_fired;
      logic [7:0]  ammo_left;
      logic [2:0]  fire_phase;
      logic [15:0] ticks_since_shot;
   } result_type;

   // Loads a timer, saturating values beyond its range.
   function automatic timer_type tload(input logic [15:0] v);
      logic [32:0] w;
      w = 33'(v);
      if (w > 33'(TIMER_MAX)) begin
         tload = TIMER_MAX;
      end else begin
         tload = timer_type'(w);
      end
   endfunction

endpackage

/* rtl/bfs_req_if.sv */
// ----------------------------------------------------------------------------
// bfs_req_if: tick channel into the sequencer
// Valid/ready handshake carrying the trigger level of one tick.
// ----------------------------------------------------------------------------
interface bfs_req_if;
   logic valid;
   logic ready;
   logic trigger_pressed;

   modport source (output valid, output trigger_pressed, input ready);
   modport sink   (input valid, input trigger_pressed, output ready);
endinterface

/* rtl/bfs_rsp_if.sv */
// ----------------------------------------------------------------------------
// bfs_rsp_if: result channel out of the sequencer
// Valid/ready handshake carrying the shot flag, ammo, phase and shot age.
// ----------------------------------------------------------------------------
interface bfs_rsp_if;
   logic        valid;
   logic        ready;
   logic        shot_fired;
   logic [7:0]  ammo_left;
   logic [2:0]  fire_phase;
   logic [15:0] ticks_since_shot;

   modport source (output valid, output shot_fired, output ammo_left,
                   output fire_phase, output ticks_since_shot, input ready);
   modport sink   (input valid, input shot_fired, input ammo_left,
                   input fire_phase, input ticks_since_shot, output ready);
endinterface

/* rtl/burst_fire_sequencer_with_reload_unit.sv */
// ----------------------------------------------------------------------------
// burst_fire_sequencer_with_reload_unit: burst fire sequencer with reload
// Path: an accepted tick word waits in the input register, then the core
//   steps it into the output register, which drives the response channel.
// Throughput: one tick word per clock unless the response channel stalls;
//   the core updates one tick's state per step, so ticks follow back to back.
// Reset: synchronous, active high; clears both pipeline stages, loads the
//   register defaults, full ammo and the idle phase.
// ----------------------------------------------------------------------------
module burst_fire_sequencer_with_reload_unit (
   input  logic                                clock,
   input  logic                                reset,
   bfs_req_if.sink                             req_if,
   bfs_rsp_if.source                           rsp_if,
   input  logic                                csr_we,
   input  logic [2:0]                          csr_index,
   input  logic [bfs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import bfs_pkg::*;

   // Input stage: one registered tick word waiting for the core.
   logic        in_valid_ff, in_valid_in;
   logic        trig_ff;

   // Output stage: the registered result word.
   logic        out_valid_ff, out_valid_in;
   result_type  out_data_ff;

   cfg_type     cfg;
   result_type  step_result;
   logic        advance;
   logic        req_fire;

   bfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The core steps when a tick word is held and the output register is
   // free or being emptied in this same cycle.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_fire = req_if.valid && req_if.ready;

   bfs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .trig    (trig_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // The input register takes a new word whenever it is empty or its word
   // moves into the core, so one tick word can wait in front of a stalled
   // result; a second one is held off until the result is taken.
   assign req_if.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         trig_ff <= req_if.trigger_pressed;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.shot_fired       = out_data_ff.shot_fired;
   assign rsp_if.ammo_left        = out_data_ff.ammo_left;
   assign rsp_if.fire_phase       = out_data_ff.fire_phase;
   assign rsp_if.ticks_since_shot = out_data_ff.ticks_since_shot;

   // A held tick word that cannot advance is still held next cycle.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("tick word dropped from input stage");

   // Every step of the core produces a result word.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("core step without result word");

   // The core never steps while an untaken result would be overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_if.ready) |-> !advance)
      else $error("result word overwritten");

endmodule

/* rtl/bfs_csr.sv */
// ----------------------------------------------------------------------------
// bfs_csr: configuration register file
// Write-only registers, one per index, cleared to their defaults at reset.
// ----------------------------------------------------------------------------
module bfs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  bfs_pkg::csr_index_type              csr_index,
   input  logic [bfs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output bfs_pkg::cfg_type                    cfg
);
   import bfs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_AMMO:     cfg_in.max_ammo          = csr_wdata[7:0];
            CSR_RELOAD_STEP:  cfg_in.reload_step       = csr_wdata[7:0];
            CSR_SHOTS:        cfg_in.shots_per_burst   = csr_wdata[7:0];
            CSR_SHOT_GAP:     cfg_in.shot_gap          = csr_wdata[15:0];
            CSR_TRIG_DELAY:   cfg_in.trigger_delay     = csr_wdata[15:0];
            CSR_HOLDOFF:      cfg_in.burst_holdoff     = csr_wdata[15:0];
            CSR_RELOAD_AFTER: cfg_in.reload_after_shot = csr_wdata[15:0];
            CSR_RELEASE_MODE: cfg_in.release_mode      = csr_wdata[1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_ammo          <= RST_MAX_AMMO;
         cfg_ff.reload_step       <= RST_RELOAD_STEP;
         cfg_ff.shots_per_burst   <= RST_SHOTS;
         cfg_ff.shot_gap          <= RST_SHOT_GAP;
         cfg_ff.trigger_delay     <= RST_TRIG_DELAY;
         cfg_ff.burst_holdoff     <= RST_HOLDOFF;
         cfg_ff.reload_after_shot <= RST_RELOAD_AFTER;
         cfg_ff.release_mode      <= RST_RELEASE_MODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/bfs_core.sv */
// ----------------------------------------------------------------------------
// bfs_core: per-tick state update of the sequencer
// Holds ammo, timers and the fire phase; on each step it runs the reload
// check and then the fire phase machine and returns the tick's result.
// ----------------------------------------------------------------------------
module bfs_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                trig,
   input  bfs_pkg::cfg_type    cfg,
   output bfs_pkg::result_type result
);
   import bfs_pkg::*;

   phase_type   phase_ff,  phase_in;
   timer_type   pcd_ff,    pcd_in;
   logic [7:0]  burst_ff,  burst_in;
   logic [7:0]  ammo_ff,   ammo_in;
   timer_type   rcd_ff,    rcd_in;
   logic [15:0] since_ff,  since_in;
   logic        fired;

   logic [7:0]  bsize;
   logic [8:0]  reload_sum;
   logic        run0, run1, run2, run3, run4, run5;

   assign bsize = (cfg.shots_per_burst == 8'd0) ? 8'd1 : cfg.shots_per_burst;

   // Next state: countdowns, reload, then the fire phases in the order in
   // which a tick can fall through them. The rearm release path loops back
   // into the idle check, so idle is evaluated after the burst phases.
   always_comb begin
      phase_in = phase_ff;
      pcd_in   = (pcd_ff != '0) ? pcd_ff - timer_type'(1) : pcd_ff;
      rcd_in   = (rcd_ff != '0) ? rcd_ff - timer_type'(1) : rcd_ff;
      since_in = (since_ff < SINCE_MAX) ? since_ff + 16'd1 : since_ff;
      burst_in = burst_ff;
      ammo_in  = ammo_ff;
      fired    = 1'b0;
      reload_sum = 9'(ammo_ff) + 9'(cfg.reload_step);

      if ((ammo_ff < cfg.max_ammo) && (rcd_in == '0)) begin
         ammo_in = (reload_sum > 9'(cfg.max_ammo)) ? cfg.max_ammo : reload_sum[7:0];
         rcd_in  = tload(16'(RELOAD_GAP));
      end

      run0 = (phase_ff == PH_IDLE);
      run1 = (phase_ff == PH_DELAY);
      run2 = (phase_ff == PH_RELEASE);
      run3 = (phase_ff == PH_GAP);
      run4 = (phase_ff == PH_HOLDOFF);
      run5 = (phase_ff == PH_REARM);

      if (!(run0 || run1 || run2 || run3 || run4 || run5)) begin
         phase_in = PH_IDLE;
      end

      if (run3 && (pcd_in == '0)) begin
         if (burst_ff > 8'd1) begin
            burst_in = burst_ff - 8'd1;
            fired    = 1'b1;
         end else begin
            burst_in = 8'd0;
            pcd_in   = tload(cfg.burst_holdoff);
            phase_in = PH_HOLDOFF;
            run4     = 1'b1;
         end
      end

      if (run4 && (pcd_in == '0)) begin
         phase_in = PH_REARM;
         run5     = 1'b1;
      end

      if (run5 && (!trig || !cfg.release_mode[RM_REARM_ON_RELEASE])) begin
         phase_in = PH_IDLE;
         run0     = 1'b1;
      end

      if (run0 && trig && (ammo_in >= bsize)) begin
         pcd_in   = tload(cfg.trigger_delay);
         phase_in = PH_DELAY;
         run1     = 1'b1;
      end

      if (run1 && (pcd_in == '0)) begin
         phase_in = PH_RELEASE;
         run2     = 1'b1;
      end

      if (run2 && (!trig || !cfg.release_mode[RM_FIRE_ON_RELEASE])) begin
         burst_in = bsize;
         fired    = 1'b1;
      end

      // A shot takes one round (never below zero) and restarts the timers.
      if (fired) begin
         ammo_in  = (ammo_in != 8'd0) ? ammo_in - 8'd1 : 8'd0;
         phase_in = PH_GAP;
         pcd_in   = tload(cfg.shot_gap);
         rcd_in   = tload(cfg.reload_after_shot);
         since_in = 16'd0;
      end
   end

   // Result of this tick.
   always_comb begin
      result.shot_fired       = fired;
      result.ammo_left        = ammo_in;
      result.fire_phase       = phase_in;
      result.ticks_since_shot = since_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pcd_ff   <= '0;
         burst_ff <= 8'd0;
         ammo_ff  <= RST_MAX_AMMO;
         rcd_ff   <= '0;
         since_ff <= 16'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         pcd_ff   <= pcd_in;
         burst_ff <= burst_in;
         ammo_ff  <= ammo_in;
         rcd_ff   <= rcd_in;
         since_ff <= since_in;
      end
   end

   // Inside a burst there is always at least one shot accounted for.
   a_gap_has_burst: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_GAP) |-> (burst_ff != 8'd0))
      else $error("shot gap phase with empty burst count");

   // A shot always leaves the machine in the shot gap phase.
   a_shot_to_gap: assert property (@(posedge clock) disable iff (reset)
      (step_en && fired) |=> (phase_ff == PH_GAP) && (since_ff == 16'd0))
      else $error("shot did not enter shot gap");

   // Ammo, phase and the shot age only change on a step.
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(ammo_ff) && $stable(phase_ff) && $stable(since_ff))
      else $error("state changed without a tick");

endmodule

/* sim/burst_fire_sequencer_with_reload_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_fire_sequencer_with_reload_unit_tb: tick-level check of the sequencer
// Drives one trigger word per tick through the request channel, predicts
// every result word with a cycle-free model of the reload step and the fire
// phases, and compares each response field by field. Directed tests cover the
// register defaults, all release modes, zero burst size, ammo above the
// maximum, a burst running out of ammo and the longest timer loads. Random
// trigger runs under changing settings follow. Both channels stall at random.
// ----------------------------------------------------------------------------
module burst_fire_sequencer_with_reload_unit_tb;
   import bfs_pkg::*;

   // The run ends in failure if it has not finished after this many cycles.
   localparam int unsigned CYCLE_LIMIT   = 200_000;
   // Cycles allowed after the last expected word before touching registers.
   localparam int unsigned SETTLE_CYCLES = 4;
   // Only this many mismatch lines are printed; all of them are counted.
   localparam int unsigned REPORT_LINES  = 40;
   localparam logic [15:0] TIMER_TOP     = 16'hFFFF;

   logic clock;
   logic reset;
   logic csr_we;
   logic [2:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   bfs_req_if req_ch ();
   bfs_rsp_if rsp_ch ();

   burst_fire_sequencer_with_reload_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Percentage of cycles in which each side holds back.
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;

   int unsigned cycle_count;
   int unsigned words_sent;
   int unsigned words_checked;
   int unsigned shots_predicted;
   int unsigned regs_written;
   int unsigned mismatch_count;

   // Result words predicted for accepted ticks, oldest first.
   result_type expected_results[$];

   // ------------------------------------------------------------------------
   // Sequencer prediction. The registers mirror what has been written to the
   // block, the rest is the tick state. Timers are 16 bits wide, the same as
   // the timer registers, so every timer load fits without saturation.
   // ------------------------------------------------------------------------
   cfg_type     settings;
   phase_type   seq_phase;
   logic [15:0] phase_timer;
   logic [15:0] reload_timer;
   logic [15:0] since_shot;
   logic [7:0]  burst_remaining;
   logic [7:0]  ammo_count;
   logic        shot_this_tick;

   function automatic void reset_prediction();
      settings.max_ammo          = RST_MAX_AMMO;
      settings.reload_step       = RST_RELOAD_STEP;
      settings.shots_per_burst   = RST_SHOTS;
      settings.shot_gap          = RST_SHOT_GAP;
      settings.trigger_delay     = RST_TRIG_DELAY;
      settings.burst_holdoff     = RST_HOLDOFF;
      settings.reload_after_shot = RST_RELOAD_AFTER;
      settings.release_mode      = RST_RELEASE_MODE;
      seq_phase       = PH_IDLE;
      phase_timer     = '0;
      reload_timer    = '0;
      since_shot      = '0;
      burst_remaining = '0;
      ammo_count      = RST_MAX_AMMO;
   endfunction

   // A burst size of zero behaves as a single shot.
   function automatic logic [7:0] burst_len();
      return (settings.shots_per_burst == 8'd0) ? 8'd1 : settings.shots_per_burst;
   endfunction

   // A shot with an empty magazine still fires; ammo simply stays at zero.
   function automatic void take_shot();
      if (ammo_count != 8'd0) begin
         ammo_count = ammo_count - 8'd1;
      end
      seq_phase      = PH_GAP;
      phase_timer    = settings.shot_gap;
      reload_timer   = settings.reload_after_shot;
      since_shot     = '0;
      shot_this_tick = 1'b1;
   endfunction

   function automatic result_type predict_tick(input logic trig);
      result_type word;
      logic [8:0] sum;
      logic rescan;
      logic held;

      shot_this_tick = 1'b0;
      if (phase_timer != 16'd0) begin
         phase_timer = phase_timer - 16'd1;
      end
      if (reload_timer != 16'd0) begin
         reload_timer = reload_timer - 16'd1;
      end
      if (since_shot != TIMER_TOP) begin
         since_shot = since_shot + 16'd1;
      end

      // Reload first. Ammo left above a lowered maximum is never touched.
      if (ammo_count < settings.max_ammo && reload_timer == 16'd0) begin
         sum = {1'b0, ammo_count} + {1'b0, settings.reload_step};
         ammo_count = (sum > {1'b0, settings.max_ammo}) ? settings.max_ammo : sum[7:0];
         reload_timer = 16'(RELOAD_GAP);
      end

      // Each phase may hand over to the next one within the same tick. Leaving
      // the rearm phase goes round once more so that a press can start a new
      // burst right away. A shot always ends the tick.
      rescan = 1'b1;
      while (rescan) begin
         rescan = 1'b0;
         held   = 1'b0;
         if (seq_phase == PH_IDLE) begin
            if (!trig || ammo_count < burst_len()) begin
               held = 1'b1;
            end else begin
               phase_timer = settings.trigger_delay;
               seq_phase   = PH_DELAY;
            end
         end
         if (!held && seq_phase == PH_DELAY) begin
            if (phase_timer != 16'd0) begin
               held = 1'b1;
            end else begin
               seq_phase = PH_RELEASE;
            end
         end
         if (!held && seq_phase == PH_RELEASE) begin
            if (!trig || !settings.release_mode[RM_FIRE_ON_RELEASE]) begin
               burst_remaining = burst_len();
               take_shot();
            end
            held = 1'b1;
         end
         if (!held && seq_phase == PH_GAP) begin
            if (phase_timer != 16'd0) begin
               held = 1'b1;
            end else if (burst_remaining > 8'd1) begin
               burst_remaining = burst_remaining - 8'd1;
               take_shot();
               held = 1'b1;
            end else begin
               burst_remaining = '0;
               phase_timer     = settings.burst_holdoff;
               seq_phase       = PH_HOLDOFF;
            end
         end
         if (!held && seq_phase == PH_HOLDOFF) begin
            if (phase_timer != 16'd0) begin
               held = 1'b1;
            end else begin
               seq_phase = PH_REARM;
            end
         end
         if (!held && seq_phase == PH_REARM) begin
            if (!trig || !settings.release_mode[RM_REARM_ON_RELEASE]) begin
               seq_phase = PH_IDLE;
               rescan    = 1'b1;
            end
         end
      end

      word.shot_fired       = shot_this_tick;
      word.ammo_left        = ammo_count;
      word.fire_phase       = seq_phase;
      word.ticks_since_shot = since_shot;
      return word;
   endfunction

   // ------------------------------------------------------------------------
   // Clock, watchdog, receiver and result checking.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_results.size());
      $display("status: fail");
      $finish;
   end

   // The receiver stalls at random, at the rate of the current traffic phase.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
         $display("%0t: result word %0d, %s: got %0d, expected %0d", $time, words_checked,
                  what, got, want);
      end
   endtask

   // Values read right after the edge are those the block saw at the edge,
   // since every signal on both sides changes by nonblocking assignment.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("word with no tick waiting", 1, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.shot_fired !== want.shot_fired) begin
               report_mismatch("shot_fired", rsp_ch.shot_fired, want.shot_fired);
            end
            if (rsp_ch.ammo_left !== want.ammo_left) begin
               report_mismatch("ammo_left", rsp_ch.ammo_left, want.ammo_left);
            end
            if (rsp_ch.fire_phase !== want.fire_phase) begin
               report_mismatch("fire_phase", rsp_ch.fire_phase, want.fire_phase);
            end
            if (rsp_ch.ticks_since_shot !== want.ticks_since_shot) begin
               report_mismatch("ticks_since_shot", rsp_ch.ticks_since_shot,
                               want.ticks_since_shot);
            end
         end
         words_checked++;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   // Offers one tick word, holding back at random first, and predicts its
   // result at the edge where it is taken. Valid stays high on return so that
   // the next word can follow back to back.
   task automatic send_tick(input logic trig);
      result_type want;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.trigger_pressed <= trig;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      want = predict_tick(trig);
      if (want.shot_fired) begin
         shots_predicted++;
      end
      expected_results.push_back(want);
      words_sent++;
   endtask

   task automatic send_run(input logic trig, input int unsigned ticks);
      repeat (ticks) send_tick(trig);
   endtask

   // Stops sending and waits until every predicted word has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Registers only change with nothing in flight. Write enable drops after
   // each write so that back-to-back writes never raise and lower it in the
   // same step.
   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MAX_AMMO:     settings.max_ammo          = value[7:0];
         CSR_RELOAD_STEP:  settings.reload_step       = value[7:0];
         CSR_SHOTS:        settings.shots_per_burst   = value[7:0];
         CSR_SHOT_GAP:     settings.shot_gap          = value;
         CSR_TRIG_DELAY:   settings.trigger_delay     = value;
         CSR_HOLDOFF:      settings.burst_holdoff     = value;
         CSR_RELOAD_AFTER: settings.reload_after_shot = value;
         CSR_RELEASE_MODE: settings.release_mode      = value[1:0];
         default: ;
      endcase
      regs_written++;
      @(posedge clock);
   endtask

   // Short timers so that bursts, holdoffs and reloads turn over quickly.
   task automatic write_quick_timers(input logic [15:0] gap, input logic [15:0] delay,
                                     input logic [15:0] holdoff, input logic [15:0] after);
      write_reg(CSR_SHOT_GAP, gap);
      write_reg(CSR_TRIG_DELAY, delay);
      write_reg(CSR_HOLDOFF, holdoff);
      write_reg(CSR_RELOAD_AFTER, after);
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Register defaults straight out of reset: one press gives a burst of
   // three shots 70 ticks apart and a 200 tick holdoff, then a second press.
   task automatic test_default_burst();
      send_run(1'b1, 1);
      send_run(1'b0, 420);
      send_run(1'b1, 2);
      send_run(1'b0, 30);
   endtask

   // Every release mode: a hold, a release, a short tap, a rest, then a long hold and a rest.
   task automatic test_release_modes();
      int unsigned mode;
      write_reg(CSR_MAX_AMMO, 16'd10);
      write_reg(CSR_RELOAD_STEP, 16'd1);
      write_reg(CSR_SHOTS, 16'd2);
      write_quick_timers(16'd2, 16'd3, 16'd4, 16'd5);
      for (mode = 0; mode < 4; mode++) begin
         write_reg(CSR_RELEASE_MODE, 16'(mode));
         send_run(1'b1, 12);
         send_run(1'b0, 6);
         send_run(1'b1, 2);
         send_run(1'b0, 12);
         send_run(1'b1, 25);
         send_run(1'b0, 15);
      end
   endtask

   // A burst size of zero fires single shots.
   task automatic test_zero_burst_size();
      write_reg(CSR_RELEASE_MODE, 16'd0);
      write_reg(CSR_SHOTS, 16'd0);
      send_run(1'b1, 3);
      send_run(1'b0, 8);
      send_run(1'b1, 1);
      send_run(1'b0, 6);
   endtask

   // Fill up to 40 with a saturating reload, then lower the maximum: ammo
   // stays above it without reloads until bursts bring it below again.
   task automatic test_ammo_over_max();
      write_reg(CSR_MAX_AMMO, 16'd40);
      write_reg(CSR_RELOAD_STEP, 16'd255);
      write_reg(CSR_SHOTS, 16'd3);
      write_quick_timers(16'd0, 16'd0, 16'd0, 16'd0);
      send_run(1'b0, 70);
      write_reg(CSR_MAX_AMMO, 16'd5);
      send_run(1'b1, 4);
      send_run(1'b0, 3);
      write_reg(CSR_RELOAD_STEP, 16'd1);
      send_run(1'b1, 45);
      send_run(1'b0, 70);
   endtask

   // Bring ammo down to a single round, start a one-shot press with a trigger
   // delay and raise the burst size while it waits: the extra shots fire on
   // an empty magazine.
   task automatic test_empty_during_burst();
      write_reg(CSR_MAX_AMMO, 16'd1);
      write_reg(CSR_SHOTS, 16'd1);
      send_run(1'b1, 20);
      send_run(1'b0, 70);
      write_reg(CSR_RELOAD_AFTER, 16'd1000);
      write_reg(CSR_TRIG_DELAY, 16'd5);
      send_run(1'b1, 1);
      write_reg(CSR_SHOTS, 16'd4);
      send_run(1'b0, 20);
   endtask

   // All timers at their largest load. The trigger delay holds the burst back
   // for the rest of the run, so this test comes last.
   task automatic test_longest_timers();
      write_reg(CSR_MAX_AMMO, 16'd255);
      write_reg(CSR_RELOAD_STEP, 16'd255);
      write_reg(CSR_RELEASE_MODE, 16'd0);
      write_reg(CSR_SHOTS, 16'd2);
      write_quick_timers(16'd0, 16'd0, 16'd0, 16'd0);
      send_run(1'b0, 150);
      write_quick_timers(TIMER_TOP, TIMER_TOP, TIMER_TOP, TIMER_TOP);
      send_run(1'b1, 1);
      send_run(1'b0, 60);
   endtask

   // New random settings, leaning on the extremes and on short timers.
   task automatic shuffle_settings();
      logic [15:0] value;
      case ($urandom_range(3))
         0: value = 16'd1;
         1: value = 16'd255;
         default: value = 16'($urandom_range(1, 20));
      endcase
      write_reg(CSR_MAX_AMMO, value);
      case ($urandom_range(3))
         0: value = 16'd1;
         1: value = 16'd255;
         default: value = 16'($urandom_range(1, 10));
      endcase
      write_reg(CSR_RELOAD_STEP, value);
      case ($urandom_range(9))
         0: value = 16'd0;
         1: value = 16'd255;
         2: value = 16'd1;
         default: value = 16'($urandom_range(1, 5));
      endcase
      write_reg(CSR_SHOTS, value);
      write_quick_timers(16'($urandom_range(0, 6)), 16'($urandom_range(0, 5)),
                         16'($urandom_range(0, 8)), 16'($urandom_range(0, 40)));
      write_reg(CSR_RELEASE_MODE, 16'($urandom_range(3)));
   endtask

   // Random trigger runs: mostly presses and releases of a few ticks, with
   // single-tick chatter mixed in. Settings change every so often, which also
   // makes the sender wait until all results are in.
   task automatic test_random_traffic(input int unsigned n_words);
      int unsigned sent_here;
      int unsigned next_shuffle;
      int unsigned run_len;
      logic level;
      sent_here    = 0;
      next_shuffle = 0;
      while (sent_here < n_words) begin
         if (sent_here >= next_shuffle) begin
            shuffle_settings();
            next_shuffle = sent_here + $urandom_range(60, 200);
         end
         level   = 1'($urandom_range(1));
         run_len = ($urandom_range(3) == 0) ? 1 : $urandom_range(1, 15);
         send_run(level, run_len);
         sent_here += run_len;
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = '0;
      csr_wdata              = '0;
      req_ch.valid           = 1'b0;
      req_ch.trigger_pressed = 1'b0;
      rsp_ch.ready           = 1'b0;
      words_sent             = 0;
      words_checked          = 0;
      shots_predicted        = 0;
      regs_written           = 0;
      mismatch_count         = 0;
      reset_prediction();

      // Sender rarely idles, receiver mostly stalls.
      sender_idle_pct   = 11;
      receiver_idle_pct = 71;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_burst();
      test_release_modes();
      test_zero_burst_size();
      test_ammo_over_max();
      test_empty_during_burst();
      test_random_traffic(225);

      // Now the sender holds back most of the time.
      sender_idle_pct   = 71;
      receiver_idle_pct = 11;
      test_random_traffic(225);

      // Full rate on both sides.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_traffic(225);
      test_longest_timers();

      wait_drained();
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch("words never returned", 0, expected_results.size());
      end

      $display("%0d tick words sent and %0d result words checked, %0d shots among them",
               words_sent, words_checked, shots_predicted);
      $display("%0d register writes across defaults, release modes and timer extremes",
               regs_written);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
